[sv/rttebt_pkg.sv]
// Shared types and constants for the rtt estimator and backoff timer.
`timescale 1ns / 1ps

package rttebt_pkg;

	localparam int ACTION_W  = 2;
	localparam int SAMPLE_W  = 21;
	localparam int RTT_W     = 32;
	localparam int TIMEOUT_W = 16;
	localparam int STEP_W    = 4;

	// Request kinds carried on the input tuser.
	localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SAMPLE  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PERSIST = 2'd2;

	// The backoff factor stops growing at 2^6.
	localparam logic [STEP_W-1:0] MAX_SHIFT = 4'd6;

	// Register byte addresses on the configuration port.
	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_INIT_SRTT   = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_INIT_RTTVAR = 3'd4;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 88;

	typedef struct packed {
		logic [RTT_W-1:0]  srtt;
		logic [RTT_W-1:0]  rttvar;
		logic [STEP_W-1:0] backoff;
	} rttebt_state_t;

endpackage

[sv/rttebt_update.sv]
// Next-state and timeout logic for one estimator request.
`timescale 1ns / 1ps

module rttebt_update import rttebt_pkg::*; #(
	parameter int TICKS_PER_SECOND = 100,
	parameter int MAX_BACKOFF_STEP = 12
) (
	input  logic [ACTION_W-1:0]        action,
	input  logic signed [SAMPLE_W-1:0] rtt_sample,
	input  rttebt_state_t              cur,
	input  logic [RTT_W-1:0]           init_srtt,
	input  logic [RTT_W-1:0]           init_rttvar,
	output rttebt_state_t              nxt,
	output logic [TIMEOUT_W-1:0]       timeout_ticks
);

	localparam logic [37:0] MIN_TICKS = 38'(TICKS_PER_SECOND);
	localparam logic [37:0] MAX_TICKS = 38'(600 * TICKS_PER_SECOND);
	localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(MAX_BACKOFF_STEP);

	logic [SAMPLE_W-1:0] mag;
	logic signed [34:0]  err;
	logic signed [34:0]  err_half;
	logic signed [34:0]  srtt_sum;
	logic [34:0]         err_abs;
	logic signed [35:0]  var_diff;
	logic signed [35:0]  var_sum;
	logic [RTT_W-1:0]    srtt_new;
	logic [RTT_W-1:0]    var_new;
	logic [32:0]         base;
	logic [2:0]          shamt;
	logic [37:0]         prod;
	logic [37:0]         clamped;

	// Sample update: the error is taken against the scaled average, and the
	// deviation tracks half of its magnitude.
	always_comb begin
		mag      = rtt_sample[SAMPLE_W-1] ? (~rtt_sample + 1'b1) : rtt_sample;
		err      = $signed({11'd0, mag, 3'b000}) - $signed({3'b000, cur.srtt});
		srtt_sum = $signed({3'b000, cur.srtt}) + (err >>> 3);
		srtt_new = (srtt_sum < 35'sd1) ? 32'd1 : srtt_sum[31:0];
		err_half = err >>> 1;
		err_abs  = err_half[34] ? 35'(-err_half) : err_half;
		var_diff = $signed({1'b0, err_abs}) - $signed({4'd0, cur.rttvar});
		var_sum  = $signed({4'd0, cur.rttvar}) + (var_diff >>> 2);
		var_new  = (var_sum < 36'sd1) ? 32'd1 : var_sum[31:0];
	end

	// Persist timeout: base interval scaled by the backoff factor, then clamped.
	always_comb begin
		base    = {3'b000, cur.srtt[31:2]} + {1'b0, cur.rttvar};
		shamt   = (cur.backoff < MAX_SHIFT) ? cur.backoff[2:0] : MAX_SHIFT[2:0];
		prod    = {6'd0, base[32:1]} << shamt;
		clamped = prod;
		if (prod < MIN_TICKS) begin
			clamped = MIN_TICKS;
		end
		if (prod > MAX_TICKS) begin
			clamped = MAX_TICKS;
		end
	end

	always_comb begin
		nxt           = cur;
		timeout_ticks = '0;
		case (action)
			ACT_RESTART: begin
				nxt.srtt    = init_srtt;
				nxt.rttvar  = init_rttvar;
				nxt.backoff = '0;
			end
			ACT_SAMPLE: begin
				nxt.srtt   = srtt_new;
				nxt.rttvar = var_new;
			end
			ACT_PERSIST: begin
				timeout_ticks = clamped[TIMEOUT_W-1:0];
				if (cur.backoff < STEP_CAP) begin
					nxt.backoff = cur.backoff + 4'd1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

[sv/rtt_estimator_backoff_timer.sv]
// Top level of the rtt estimator with backed-off persist timer.
`timescale 1ns / 1ps

// Usage
// Each request on the slave stream carries a kind on s_tuser (restart, rtt
// sample or persist timeout) and a signed tick sample on s_tdata. Every
// request produces exactly one result on the master stream: the persist
// timeout (zero for other kinds) and the smoothed rtt, deviation and
// backoff step as they stand after the request.
// A request is registered at acceptance; once the result register is free,
// it is applied to the estimator state and loaded into the result register,
// from which m_tvalid is driven. One request per cycle is sustained while
// the receiver takes results; the rate is set by the single state update
// between the input register and the result register, which also keeps
// back-to-back requests ordered.
// When the receiver stalls, the result register holds and the input
// register fills; s_tready drops only when both are occupied.
// Reset clears the estimator state, both initial-value registers and all
// valid flags. The initial values are written over the APB port at byte
// addresses 0 and 4 and are loaded by a restart request.

module rtt_estimator_backoff_timer import rttebt_pkg::*; #(
	parameter int TICKS_PER_SECOND = 100,
	parameter int MAX_BACKOFF_STEP = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Slave stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [20:0] rtt_sample, [23:21] zero
	input  logic [ACTION_W-1:0]    s_tuser,   // [1:0] action
	// Master stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [15:0] timeout_ticks, [47:16] smoothed_rtt,
	                                          // [79:48] rtt_deviation, [83:80] backoff_step,
	                                          // [87:84] zero
	// Configuration port.
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic [RTT_W-1:0] init_srtt_q;
	logic [RTT_W-1:0] init_rttvar_q;

	logic                       valid_s1;
	logic [ACTION_W-1:0]        action_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;

	rttebt_state_t        state_q;
	rttebt_state_t        state_nxt;
	logic [TIMEOUT_W-1:0] timeout_nxt;

	logic                 out_valid_q;
	logic [TIMEOUT_W-1:0] out_timeout_q;
	rttebt_state_t        out_state_q;

	logic out_free;
	logic advance;

	// The result register can take a new value when it is empty or being read.
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Configuration registers; only bit 2 of the address selects a register.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_srtt_q   <= '0;
			init_rttvar_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == ADDR_INIT_RTTVAR[2]) begin
				init_rttvar_q <= pwdata;
			end else begin
				init_srtt_q <= pwdata;
			end
		end
	end

	assign prdata = (paddr[2] == ADDR_INIT_SRTT[2]) ? init_srtt_q : init_rttvar_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			sample_s1 <= $signed(s_tdata[SAMPLE_W-1:0]);
		end
	end

	rttebt_update #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND),
		.MAX_BACKOFF_STEP(MAX_BACKOFF_STEP)
	) u_update (
		.action       (action_s1),
		.rtt_sample   (sample_s1),
		.cur          (state_q),
		.init_srtt    (init_srtt_q),
		.init_rttvar  (init_rttvar_q),
		.nxt          (state_nxt),
		.timeout_ticks(timeout_nxt)
	);

	// Estimator state moves only as a request passes into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_timeout_q <= timeout_nxt;
			out_state_q   <= state_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_state_q.backoff, out_state_q.rttvar,
		out_state_q.srtt, out_timeout_q};

endmodule

[dv/testbench.sv]
// Self-checking testbench for the rtt estimator with backed-off persist timer.
`timescale 1ns / 1ps

import rttebt_pkg::*;

// One result as the block should report it.
typedef struct packed {
	logic [TIMEOUT_W-1:0] timeout;
	logic [RTT_W-1:0]     srtt;
	logic [RTT_W-1:0]     rttvar;
	logic [STEP_W-1:0]    step;
} estimate_t;

// Tracks the estimator state alongside the block and checks its results in order.
class rtt_tracker;
	int unsigned          tick_rate;
	int unsigned          step_limit;
	logic [RTT_W-1:0]     init_srtt;
	logic [RTT_W-1:0]     init_rttvar;
	logic [RTT_W-1:0]     srtt;
	logic [RTT_W-1:0]     rttvar;
	logic [STEP_W-1:0]    step;
	estimate_t            pending[$];
	int                   mismatches;

	function new(int unsigned rate, int unsigned limit);
		tick_rate   = rate;
		step_limit  = limit;
		init_srtt   = '0;
		init_rttvar = '0;
		srtt        = '0;
		rttvar      = '0;
		step        = '0;
		mismatches  = 0;
	endfunction

	function void set_initial(logic [PADDR_W-1:0] addr, logic [31:0] value);
		if (addr == ADDR_INIT_SRTT)
			init_srtt = value;
		else if (addr == ADDR_INIT_RTTVAR)
			init_rttvar = value;
	endfunction

	function void report(string what, logic [63:0] want, logic [63:0] got);
		if (mismatches < 10)
			$display("mismatch in %s: expected %0h, got %0h", what, want, got);
		mismatches++;
	endfunction

	function void compare(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got)
			report(what, want, got);
	endfunction

	// Smoothing update; the error is shifted arithmetically, so it rounds down.
	function void apply_sample(logic [SAMPLE_W-1:0] raw);
		longint mag;
		longint err;
		longint s;
		longint v;
		mag = {{(64-SAMPLE_W){raw[SAMPLE_W-1]}}, raw};
		if (mag < 0)
			mag = -mag;
		s = {32'd0, srtt};
		v = {32'd0, rttvar};
		err = mag * 8 - s;
		s = s + (err >>> 3);
		srtt = (s >= 1) ? s[31:0] : 32'd1;
		err = err >>> 1;
		if (err < 0)
			err = -err;
		v = v + ((err - v) >>> 2);
		rttvar = (v >= 1) ? v[31:0] : 32'd1;
	endfunction

	// The product is kept at full width so that the upper clamp saturates it.
	function logic [TIMEOUT_W-1:0] persist_timeout();
		logic [63:0] t;
		int unsigned sh;
		t = ({32'd0, srtt >> 2} + {32'd0, rttvar}) >> 1;
		sh = (step < MAX_SHIFT) ? step : MAX_SHIFT;
		t = t << sh;
		if (t < 64'(tick_rate))
			t = 64'(tick_rate);
		if (t > 64'(600) * tick_rate)
			t = 64'(600) * tick_rate;
		if (step < step_limit)
			step = step + 1'b1;
		return t[TIMEOUT_W-1:0];
	endfunction

	function void note_request(logic [ACTION_W-1:0] act, logic [SAMPLE_W-1:0] raw);
		estimate_t e;
		e.timeout = '0;
		case (act)
			ACT_RESTART: begin
				srtt   = init_srtt;
				rttvar = init_rttvar;
				step   = '0;
			end
			ACT_SAMPLE: apply_sample(raw);
			ACT_PERSIST: e.timeout = persist_timeout();
			default: ;
		endcase
		e.srtt   = srtt;
		e.rttvar = rttvar;
		e.step   = step;
		pending.push_back(e);
	endfunction

	function void check_result(logic [OUT_TDATA_W-1:0] word);
		estimate_t e;
		if (pending.size() == 0) begin
			report("unrequested result (smoothed_rtt shown)", 0, word[47:16]);
			return;
		end
		e = pending.pop_front();
		compare("timeout_ticks", e.timeout, word[15:0]);
		compare("smoothed_rtt", e.srtt, word[47:16]);
		compare("rtt_deviation", e.rttvar, word[79:48]);
		compare("backoff_step", e.step, word[83:80]);
		compare("tdata padding", 0, word[87:84]);
	endfunction

	function int outstanding();
		return pending.size();
	endfunction

	function void finish_check();
		if (pending.size() != 0)
			report("results never delivered (count)", 0, pending.size());
	endfunction
endclass

module testbench;

	localparam int TICKS_PER_SECOND = 100;
	localparam int MAX_BACKOFF_STEP = 12;
	localparam int RESET_CYCLES     = 7;
	localparam int ITEMS_PER_PHASE  = 400;
	// Long enough for the input and result registers to fill and s_tready to drop.
	localparam int LONG_HOLD_CYCLES = 64;
	localparam int DRAIN_LIMIT      = 2000;
	// The slowest legal run needs well under a tenth of this limit.
	localparam int TIME_LIMIT_NS    = 5_000_000;
	// The block treats the fourth action code as a no-op.
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [20:0] rtt_sample, [23:21] zero
	logic [ACTION_W-1:0]    s_tuser  = '0;   // [1:0] action
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // [15:0] timeout_ticks, [47:16] smoothed_rtt,
	                                         // [79:48] rtt_deviation, [83:80] backoff_step,
	                                         // [87:84] zero
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [PADDR_W-1:0]     paddr    = '0;
	logic [31:0]            pwdata   = '0;
	logic [31:0]            prdata;
	logic                   pready;

	// Idling controls, set by the stimulus process and read by the drivers.
	bit sender_idles  = 1'b0;
	bit sink_idles    = 1'b0;
	bit hold_results  = 1'b0;

	rtt_tracker tracker = new(TICKS_PER_SECOND, MAX_BACKOFF_STEP);

	rtt_estimator_backoff_timer #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND),
		.MAX_BACKOFF_STEP(MAX_BACKOFF_STEP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 0;
	end

	// Every process below drives with nonblocking assignments at the rising edge
	// and reads handshake signals in the active region of that edge, so it sees
	// the values that the block itself sampled.

	// APB write followed by a read-back of the same register. The write lands at
	// the edge that ends the access cycle; the read data is taken at the same
	// point of the read transfer.
	task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tracker.set_initial(addr, value);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tracker.compare("register read-back", value, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_initial(input logic [31:0] init_srtt, input logic [31:0] init_rttvar);
		write_register(ADDR_INIT_SRTT, init_srtt);
		write_register(ADDR_INIT_RTTVAR, init_rttvar);
	endtask

	// Offers one request and returns at the edge where it is accepted. tvalid is
	// left high so that back-to-back requests go out without a bubble; it is
	// only lowered by an idle burst or by the drain.
	task automatic send_request(input logic [ACTION_W-1:0] act,
	                            input logic [SAMPLE_W-1:0] sample);
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10))
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {{(IN_TDATA_W-SAMPLE_W){1'b0}}, sample};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.note_request(act, sample);
	endtask

	// Stops offering and waits until every predicted result has come back or the drain limit runs out.
	task automatic drain_results();
		int waited = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4)
			@(posedge clk);
	endtask

	// Mostly short and mid-size samples so the smoothed values stay in a range
	// where the floor at one and the clamps actually trigger, plus full-width
	// random values, the two ends of the field and the values one and minus one.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] val;
		case ($urandom_range(0, 3))
			0: val = SAMPLE_W'($urandom_range(0, 7));
			1: val = SAMPLE_W'($urandom_range(0, 3000));
			2: val = SAMPLE_W'($urandom);
			default: begin
				case ($urandom_range(0, 3))
					0: val = 21'h0F_FFFF;
					1: val = 21'h10_0000;
					2: val = 21'h1F_FFFF;
					default: val = 21'd1;
				endcase
			end
		endcase
		if (val <= 21'd3000 && $urandom_range(0, 1) == 1)
			val = -val;
		return val;
	endfunction

	function automatic logic [ACTION_W-1:0] pick_action();
		int unsigned roll = $urandom_range(0, 99);
		if (roll < 5)
			return ACT_RESTART;
		if (roll < 9)
			return ACT_UNUSED;
		if (roll < 55)
			return ACT_SAMPLE;
		return ACT_PERSIST;
	endfunction

	// Each phase starts from the freshly loaded initial values.
	task automatic run_random(input int count);
		send_request(ACT_RESTART, pick_sample());
		repeat (count)
			send_request(pick_action(), pick_sample());
	endtask

	// Hand-picked requests: a persist request straight out of reset (clamped up to
	// one second), a run of persist requests that walks the backoff factor up to its
	// cap of 64 and the step into saturation, the extreme samples, a zero sample that
	// drives the error negative, and the unused action code.
	task automatic run_directed();
		send_request(ACT_PERSIST, '0);
		send_request(ACT_RESTART, '0);
		repeat (14)
			send_request(ACT_PERSIST, '0);
		send_request(ACT_SAMPLE, 21'h0F_FFFF);
		send_request(ACT_SAMPLE, 21'h10_0000);
		send_request(ACT_PERSIST, '0);
		send_request(ACT_SAMPLE, 21'd0);
		send_request(ACT_SAMPLE, 21'h1F_FFFF);
		send_request(ACT_SAMPLE, 21'd1);
		send_request(ACT_UNUSED, SAMPLE_W'($urandom));
		send_request(ACT_RESTART, '0);
		send_request(ACT_PERSIST, '0);
	endtask

	// Result sink: random stall bursts, and one long hold-off on request that
	// fills both internal registers so that the block has to stall its input.
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (hold_results) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES)
					@(posedge clk);
				hold_results = 1'b0;
				m_tready <= 1'b1;
			end else if (sink_idles && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10))
					@(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	initial begin : stimulus
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);
		sender_idles = 1'b1;
		sink_idles   = 1'b1;

		// Realistic starting point: 250 ticks scaled by eight, modest deviation.
		load_initial(32'd2000, 32'd60);
		run_directed();
		drain_results();

		// Zero initial values: samples of zero hit the floor at one.
		load_initial(32'd0, 32'd0);
		run_random(ITEMS_PER_PHASE);
		drain_results();

		// All-ones initial values: the persist product saturates at the top clamp.
		load_initial(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random(ITEMS_PER_PHASE);
		drain_results();

		// Full-width random values, with one long hold-off on the result side
		// while requests keep coming.
		load_initial($urandom, $urandom);
		hold_results = 1'b1;
		run_random(ITEMS_PER_PHASE);
		drain_results();

		load_initial($urandom_range(0, 8 * 5000), $urandom_range(0, 5000));
		run_random(ITEMS_PER_PHASE);
		drain_results();

		// Last stretch at full rate on both sides.
		sender_idles = 1'b0;
		sink_idles   = 1'b0;
		load_initial($urandom_range(0, 8 * 2000), $urandom_range(0, 2000));
		run_random(ITEMS_PER_PHASE);
		drain_results();

		repeat (10)
			@(posedge clk);
		tracker.finish_check();
		if (tracker.mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIME_LIMIT_NS);
		$display("testbench NOT OK");
		$finish;
	end

endmodule

[filelist.f]
sv/rttebt_pkg.sv
sv/rttebt_update.sv
sv/rtt_estimator_backoff_timer.sv
dv/testbench.sv
